/* src/sap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg
// Types, codes and helpers shared by the short APDU parser modules.
// ----------------------------------------------------------------------------
package sap_pkg;

   // Number of header bytes (CLA, INS, P1, P2) and index of the last one.
   localparam int unsigned HeaderBytes = 4;
   localparam logic [1:0] HEADER_LAST = 2'd3;

   // A received Le of zero stands for this length.
   localparam logic [8:0] LE_ZERO_MEANS = 9'd256;

   // Result kinds.
   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // APDU case codes as reported in a summary.
   typedef enum logic [1:0] {
      CASE_1 = 2'd0,
      CASE_2 = 2'd1,
      CASE_3 = 2'd2,
      CASE_4 = 2'd3
   } apdu_case_type;

   // Parse status codes as reported in a summary.
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_SHORT_HEADER = 2'd1,
      ST_SHORT_DATA   = 2'd2,
      ST_EXTRA        = 2'd3
   } status_type;

   // Parser phases, one-hot.
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LENGTH = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_LE     = 5'b01000,
      PH_TRAIL  = 5'b10000
   } phase_type;

   typedef logic [HeaderBytes-1:0][7:0] header_type;

   // One queue entry: an optional data byte followed by an optional summary.
   typedef struct packed {
      logic          has_body;
      logic [7:0]    body;
      logic          has_summary;
      header_type    header;
      logic [7:0]    lc;
      logic [8:0]    le;
      apdu_case_type apdu_case;
      status_type    status;
   } entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // Decode a received Le byte.
   function automatic logic [8:0] decode_le(input logic [7:0] b);
      decode_le = (b == 8'd0) ? LE_ZERO_MEANS : {1'b0, b};
   endfunction

endpackage

/* src/sap_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_front
// Front end: accepts one APDU byte per cycle while accept_i is high, tracks
// the parse phase and turns each byte into at most one queue entry.
// ----------------------------------------------------------------------------
module sap_front
   import sap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] data_byte_i,
   input  logic       last_byte_i,
   input  logic       accept_i,
   output logic       entry_valid_o,
   output entry_type  entry_o
);

   phase_type  phase_ff, phase_in;
   logic [1:0] hidx_ff, hidx_in;
   header_type header_ff, header_in;
   logic [7:0] lc_ff, lc_in;
   logic [7:0] rem_ff, rem_in;
   logic [8:0] le_ff, le_in;
   status_type err_ff, err_in;

   header_type hdr_cur;
   logic [7:0] rem_dec;
   logic [8:0] le_cur;
   entry_type  entry;

   // Next state and entry for the byte on the input.
   always_comb begin
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      header_in = header_ff;
      lc_in     = lc_ff;
      rem_in    = rem_ff;
      le_in     = le_ff;
      err_in    = err_ff;
      hdr_cur   = header_ff;
      rem_dec   = rem_ff - 8'd1;
      le_cur    = decode_le(data_byte_i);

      entry             = '0;
      entry.body        = data_byte_i;
      entry.lc          = lc_ff;
      entry.le          = le_ff;
      entry.apdu_case   = CASE_1;
      entry.status      = ST_OK;

      unique case (phase_ff)
         PH_LENGTH: begin
            if (last_byte_i) begin
               entry.has_summary = 1'b1;
               entry.le          = le_cur;
               entry.apdu_case   = CASE_2;
            end else begin
               lc_in    = data_byte_i;
               rem_in   = data_byte_i;
               phase_in = (data_byte_i == 8'd0) ? PH_LE : PH_DATA;
            end
         end
         PH_DATA: begin
            entry.has_body = 1'b1;
            if (last_byte_i) begin
               entry.has_summary = 1'b1;
               entry.apdu_case   = CASE_3;
               entry.status      = (rem_dec != 8'd0) ? ST_SHORT_DATA : ST_OK;
            end else begin
               rem_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_LE;
               end
            end
         end
         PH_LE: begin
            if (last_byte_i) begin
               entry.has_summary = 1'b1;
               entry.le          = le_cur;
               entry.apdu_case   = CASE_4;
            end else begin
               le_in    = le_cur;
               err_in   = ST_EXTRA;
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            if (last_byte_i) begin
               entry.has_summary = 1'b1;
               entry.apdu_case   = CASE_4;
               entry.status      = err_ff;
            end
         end
         default: begin
            // Header phase; unused phase codes behave the same way.
            hdr_cur[hidx_ff] = data_byte_i;
            header_in        = hdr_cur;
            if (last_byte_i) begin
               entry.has_summary = 1'b1;
               entry.status      = (hidx_ff != HEADER_LAST) ? ST_SHORT_HEADER : ST_OK;
            end else if (hidx_ff == HEADER_LAST) begin
               hidx_in  = 2'd0;
               phase_in = PH_LENGTH;
            end else begin
               hidx_in  = hidx_ff + 2'd1;
               phase_in = PH_HEADER;
            end
         end
      endcase

      entry.header = hdr_cur;

      // A summary closes the APDU and returns every field to its reset value.
      if (entry.has_summary) begin
         phase_in  = PH_HEADER;
         hidx_in   = 2'd0;
         header_in = '0;
         lc_in     = 8'd0;
         rem_in    = 8'd0;
         le_in     = 9'd0;
         err_in    = ST_OK;
      end
   end

   // Parser state registers, advanced once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hidx_ff   <= 2'd0;
         header_ff <= '0;
         lc_ff     <= 8'd0;
         rem_ff    <= 8'd0;
         le_ff     <= 9'd0;
         err_ff    <= ST_OK;
      end else if (accept_i) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         header_ff <= header_in;
         lc_ff     <= lc_in;
         rem_ff    <= rem_in;
         le_ff     <= le_in;
         err_ff    <= err_in;
      end
   end

   assign entry_valid_o = accept_i && (entry.has_body || entry.has_summary);
   assign entry_o       = entry;

`ifndef ASSERT_OFF
   // The header index only moves while the header is being collected.
   a_hidx_in_header: assert property (@(posedge clock) disable iff (reset)
      (hidx_ff != 2'd0) |-> (phase_ff == PH_HEADER))
      else $error("header index set outside the header phase");

   // The data phase always owes at least one byte.
   a_data_owes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (rem_ff != 8'd0))
      else $error("data phase with nothing left to receive");

   // A held error only exists after Le, while trailing bytes are dropped.
   a_err_in_trail: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK) |-> (phase_ff == PH_TRAIL))
      else $error("sticky error outside the trailing phase");
`endif

endmodule

/* src/sap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_queue
// Short queue that decouples the parser front end from the result back end.
// ----------------------------------------------------------------------------
module sap_queue
   import sap_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_i,
   input  entry_type entry_i,
   input  logic      pop_i,
   output logic      full_o,
   output head_type  head_o
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

   entry_type     entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign do_pop = pop_i && (count_ff != '0);

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_i && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_i) begin
         entries_ff[wr_ptr_ff] <= entry_i;
      end
   end

   assign full_o       = (count_ff == FullCnt);
   assign head_o.valid = (count_ff != '0);
   assign head_o.entry = entries_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("write into a full queue");
`endif

endmodule

/* src/sap_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_back
// Back end: expands each queue entry into its results and holds the oldest
// waiting result in an output register.
// ----------------------------------------------------------------------------
module sap_back
   import sap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head_i,
   output logic       head_pop_o,
   input  logic       pop,
   output logic       empty,
   output logic       result_kind_o,
   output logic [7:0] body_byte_o,
   output logic [7:0] class_byte_o,
   output logic [7:0] instruction_byte_o,
   output logic [7:0] param_one_o,
   output logic [7:0] param_two_o,
   output logic [7:0] command_length_o,
   output logic [8:0] expected_length_o,
   output logic [1:0] apdu_case_o,
   output logic [1:0] parse_status_o,
   output logic       end_of_run_o
);

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic       load;
   logic       emit_body;

   logic       kind_ff, kind_in;
   logic [7:0] body_ff, body_in;
   header_type hdr_ff, hdr_in;
   logic [7:0] lc_ff, lc_in;
   logic [8:0] le_ff, le_in;
   logic [1:0] case_ff, case_in;
   logic [1:0] status_ff, status_in;
   logic       end_ff, end_in;

   // The output register takes a new result when it is free or being emptied.
   assign load      = head_i.valid && (!valid_ff || pop);
   assign emit_body = head_i.entry.has_body && !second_ff;

   // Choose the next result from the head entry.
   always_comb begin
      valid_in   = valid_ff;
      second_in  = second_ff;
      head_pop_o = 1'b0;
      kind_in    = KIND_BODY;
      body_in    = 8'd0;
      hdr_in     = '0;
      lc_in      = 8'd0;
      le_in      = 9'd0;
      case_in    = 2'd0;
      status_in  = 2'd0;
      end_in     = 1'b1;
      if (pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (emit_body) begin
            body_in = head_i.entry.body;
            end_in  = !head_i.entry.has_summary;
            if (head_i.entry.has_summary) begin
               second_in = 1'b1;
            end else begin
               head_pop_o = 1'b1;
            end
         end else begin
            kind_in    = KIND_SUMMARY;
            hdr_in     = head_i.entry.header;
            lc_in      = head_i.entry.lc;
            le_in      = head_i.entry.le;
            case_in    = head_i.entry.apdu_case;
            status_in  = head_i.entry.status;
            second_in  = 1'b0;
            head_pop_o = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         body_ff   <= body_in;
         hdr_ff    <= hdr_in;
         lc_ff     <= lc_in;
         le_ff     <= le_in;
         case_ff   <= case_in;
         status_ff <= status_in;
         end_ff    <= end_in;
      end
   end

   assign empty              = !valid_ff;
   assign result_kind_o      = kind_ff;
   assign body_byte_o        = body_ff;
   assign class_byte_o       = hdr_ff[0];
   assign instruction_byte_o = hdr_ff[1];
   assign param_one_o        = hdr_ff[2];
   assign param_two_o        = hdr_ff[3];
   assign command_length_o   = lc_ff;
   assign expected_length_o  = le_ff;
   assign apdu_case_o        = case_ff;
   assign parse_status_o     = status_ff;
   assign end_of_run_o       = end_ff;

`ifndef ASSERT_OFF
   // Half-way through an entry, the head must still hold a byte and a summary.
   a_second_half: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (head_i.valid && head_i.entry.has_body && head_i.entry.has_summary))
      else $error("summary pending without a matching head entry");
`endif

endmodule

/* src/short_apdu_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_apdu_parser_top
// Short command APDU parser: passes command data bytes through and reports
// a header, length and status summary on the final byte.
// ----------------------------------------------------------------------------
// The parser takes one APDU byte per clock whenever full is low; full rises
// only when all QUEUE_DEPTH entries of the queue between the parser and the
// result stage are occupied. Results leave one per clock through the output
// register while pop is high; a final data byte yields two results (the
// byte, then the summary) and holds the result stage for both. Each result
// is written into the queue when its byte is accepted and then moves into
// the output register when it is free or being emptied. Header, Lc and Le
// bytes cause no result until the final byte, which always ends the APDU
// with a summary and leaves the parser ready for the next command.
module short_apdu_parser_top
   import sap_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       push,
   output logic       full,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_body_byte,
   output logic [7:0] rsp_class_byte,
   output logic [7:0] rsp_instruction_byte,
   output logic [7:0] rsp_param_one,
   output logic [7:0] rsp_param_two,
   output logic [7:0] rsp_command_length,
   output logic [8:0] rsp_expected_length,
   output logic [1:0] rsp_apdu_case,
   output logic [1:0] rsp_parse_status,
   output logic       rsp_end_of_run,
   output logic       empty,
   input  logic       pop
);

   logic      accept;
   logic      entry_valid;
   entry_type entry;
   head_type  head;
   logic      head_pop;

   // A transaction is taken whenever the queue has room.
   assign accept = push && !full;

   sap_front u_front (
      .clock         (clock),
      .reset         (reset),
      .data_byte_i   (req_data_byte),
      .last_byte_i   (req_last_byte),
      .accept_i      (accept),
      .entry_valid_o (entry_valid),
      .entry_o       (entry)
   );

   sap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (entry_valid),
      .entry_i (entry),
      .pop_i   (head_pop),
      .full_o  (full),
      .head_o  (head)
   );

   sap_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_i             (head),
      .head_pop_o         (head_pop),
      .pop                (pop),
      .empty              (empty),
      .result_kind_o      (rsp_result_kind),
      .body_byte_o        (rsp_body_byte),
      .class_byte_o       (rsp_class_byte),
      .instruction_byte_o (rsp_instruction_byte),
      .param_one_o        (rsp_param_one),
      .param_two_o        (rsp_param_two),
      .command_length_o   (rsp_command_length),
      .expected_length_o  (rsp_expected_length),
      .apdu_case_o        (rsp_apdu_case),
      .parse_status_o     (rsp_parse_status),
      .end_of_run_o       (rsp_end_of_run)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for short_apdu_parser_top. A fixed list of command
// APDUs covers the header, length and status corner cases, then random APDUs
// (mostly well formed, some cut short, padded or pure noise) follow. A
// behavioral parser inside the bench predicts every result, and each popped
// transaction is compared with the oldest prediction. Both sides idle at
// random, and the last part of the run streams at full rate.
// ----------------------------------------------------------------------------
module tb;
   import sap_pkg::*;

   localparam int unsigned NUM_ITEMS  = 650;
   localparam int unsigned CALM_ITEMS = 560;
   localparam int unsigned NUM_DIRECT = 25;
   localparam int unsigned MAX_SHOWN  = 10;
   localparam int unsigned DRAIN_WAIT = 20;
   localparam int unsigned LONG_ROOM  = 300;

   // Shapes of random APDUs.
   typedef enum int unsigned {
      FORM_CASE1, FORM_CASE2, FORM_CASE3, FORM_CASE4,
      FORM_SHORT_HDR, FORM_SHORT_DATA, FORM_EXTRA, FORM_NOISE
   } apdu_form_type;

   // One result transaction as seen on the rsp_ ports.
   typedef struct packed {
      logic       kind;
      logic [7:0] body;
      logic [7:0] cla;
      logic [7:0] ins;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] lc;
      logic [8:0] le;
      logic [1:0] acase;
      logic [1:0] status;
      logic       eor;
   } parser_out_type;

   // One directed byte, with a hand-written summary where typed is set.
   typedef struct packed {
      logic [7:0]    b;
      logic          fin;
      logic          typed;
      logic [7:0]    cla;
      logic [7:0]    ins;
      logic [7:0]    p1;
      logic [7:0]    p2;
      logic [7:0]    lc;
      logic [8:0]    le;
      apdu_case_type ac;
      status_type    st;
   } step_row_type;

   logic       clock;
   logic       reset;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       push;
   logic       full;
   logic       rsp_result_kind;
   logic [7:0] rsp_body_byte;
   logic [7:0] rsp_class_byte;
   logic [7:0] rsp_instruction_byte;
   logic [7:0] rsp_param_one;
   logic [7:0] rsp_param_two;
   logic [7:0] rsp_command_length;
   logic [8:0] rsp_expected_length;
   logic [1:0] rsp_apdu_case;
   logic [1:0] rsp_parse_status;
   logic       rsp_end_of_run;
   logic       empty;
   logic       pop;

   // Predicted results still owed by the block, oldest first.
   parser_out_type parser_out_q[$];
   int unsigned    bad_count;
   int unsigned    sent_count;
   bit             calm;

   // Shadow copy of the parser state.
   phase_type     ph;
   logic [1:0]    hdr_idx;
   header_type    hdr;
   logic [7:0]    lc_seen;
   logic [7:0]    data_left;
   logic [8:0]    le_seen;
   status_type    held_err;

   // Directed APDUs: short header, case 2 with Le of zero, case 3, data
   // shorter than Lc with the largest Lc, and zero Lc followed by extra bytes.
   step_row_type dir_rows [NUM_DIRECT] = '{
      '{8'hFF, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_SHORT_HEADER},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b1, 1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 9'd256, CASE_2, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h80, 1'b1, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 9'd0, CASE_3, ST_OK},
      '{8'h7F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b1, 1'b1, 8'h7F, 8'h80, 8'h01, 8'hFE, 8'hFF, 9'd0, CASE_3, ST_SHORT_DATA},
      '{8'h12, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h34, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h56, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h78, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, CASE_1, ST_OK},
      '{8'hAA, 1'b1, 1'b1, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 9'h0FF, CASE_4, ST_EXTRA}
   };

   short_apdu_parser_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .push                 (push),
      .full                 (full),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_body_byte        (rsp_body_byte),
      .rsp_class_byte       (rsp_class_byte),
      .rsp_instruction_byte (rsp_instruction_byte),
      .rsp_param_one        (rsp_param_one),
      .rsp_param_two        (rsp_param_two),
      .rsp_command_length   (rsp_command_length),
      .rsp_expected_length  (rsp_expected_length),
      .rsp_apdu_case        (rsp_apdu_case),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_end_of_run       (rsp_end_of_run),
      .empty                (empty),
      .pop                  (pop)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Return the shadow parser to its idle state.
   task automatic clear_parser();
      ph        = PH_HEADER;
      hdr_idx   = '0;
      hdr       = '0;
      lc_seen   = '0;
      data_left = '0;
      le_seen   = '0;
      held_err  = ST_OK;
   endtask

   // Queue an end-of-APDU summary and start over.
   task automatic owe_summary(input apdu_case_type ac, input status_type st);
      parser_out_type r;
      r        = '0;
      r.kind   = KIND_SUMMARY;
      r.cla    = hdr[0];
      r.ins    = hdr[1];
      r.p1     = hdr[2];
      r.p2     = hdr[3];
      r.lc     = lc_seen;
      r.le     = le_seen;
      r.acase  = ac;
      r.status = st;
      r.eor    = 1'b1;
      parser_out_q.push_back(r);
      clear_parser();
   endtask

   // Queue a passed-through command data byte.
   task automatic owe_body(input logic [7:0] b, input logic eor);
      parser_out_type r;
      r      = '0;
      r.kind = KIND_BODY;
      r.body = b;
      r.eor  = eor;
      parser_out_q.push_back(r);
   endtask

   // Advance the shadow parser by one accepted byte.
   task automatic track_apdu_byte(input logic [7:0] b, input logic fin);
      logic [8:0] le_val;
      le_val = (b == 8'd0) ? LE_ZERO_MEANS : {1'b0, b};
      case (ph)
         PH_LENGTH: begin
            if (fin) begin
               le_seen = le_val;
               owe_summary(CASE_2, ST_OK);
            end else begin
               lc_seen   = b;
               data_left = b;
               ph        = (b == 8'd0) ? PH_LE : PH_DATA;
            end
         end
         PH_DATA: begin
            data_left = data_left - 8'd1;
            if (fin) begin
               owe_body(b, 1'b0);
               owe_summary(CASE_3, (data_left != 8'd0) ? ST_SHORT_DATA : ST_OK);
            end else begin
               owe_body(b, 1'b1);
               if (data_left == 8'd0) ph = PH_LE;
            end
         end
         PH_LE: begin
            le_seen = le_val;
            if (fin) begin
               owe_summary(CASE_4, ST_OK);
            end else begin
               held_err = ST_EXTRA;
               ph       = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            if (fin) owe_summary(CASE_4, held_err);
         end
         default: begin
            hdr[hdr_idx] = b;
            if (fin) begin
               owe_summary(CASE_1, (hdr_idx != HEADER_LAST) ? ST_SHORT_HEADER : ST_OK);
            end else if (hdr_idx == HEADER_LAST) begin
               hdr_idx = '0;
               ph      = PH_LENGTH;
            end else begin
               hdr_idx = hdr_idx + 2'd1;
            end
         end
      endcase
   endtask

   // Offer one byte, possibly after a short idle burst, and wait until taken.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!calm && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_data_byte <= b;
      req_last_byte <= fin;
      push          <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      track_apdu_byte(b, fin);
      sent_count++;
      if (sent_count >= CALM_ITEMS) calm = 1'b1;
   endtask

   // One random command APDU; most are well formed, some broken or noise.
   task automatic send_random_apdu();
      int unsigned   pick;
      int unsigned   n;
      int unsigned   lc;
      int unsigned   lc_min;
      apdu_form_type form;
      pick = $urandom_range(0, 99);
      if (pick < 10)      form = FORM_CASE1;
      else if (pick < 25) form = FORM_CASE2;
      else if (pick < 45) form = FORM_CASE3;
      else if (pick < 70) form = FORM_CASE4;
      else if (pick < 78) form = FORM_SHORT_HDR;
      else if (pick < 86) form = FORM_SHORT_DATA;
      else if (pick < 94) form = FORM_EXTRA;
      else                form = FORM_NOISE;

      // Noise may leave the parser anywhere; the next APDU picks up from there.
      if (form == FORM_NOISE) begin
         repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         return;
      end
      if (form == FORM_SHORT_HDR) begin
         n = $urandom_range(1, 3);
         for (int unsigned k = 1; k <= n; k++) send_byte(8'($urandom_range(0, 255)), k == n);
         return;
      end

      // Header, ending the APDU here for case 1.
      for (int unsigned k = 0; k < HeaderBytes; k++)
         send_byte(8'($urandom_range(0, 255)), form == FORM_CASE1 && k == HeaderBytes - 1);
      if (form == FORM_CASE1) return;
      if (form == FORM_CASE2) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         return;
      end

      // Lc is mostly small, now and then large while the run has room for it.
      lc_min = (form == FORM_CASE3) ? 1 : (form == FORM_SHORT_DATA) ? 2 : 0;
      if ($urandom_range(0, 15) == 0 && sent_count + LONG_ROOM < NUM_ITEMS)
         lc = $urandom_range(9, 255);
      else
         lc = $urandom_range(lc_min, 8);
      send_byte(8'(lc), 1'b0);
      n = (form == FORM_SHORT_DATA) ? $urandom_range(1, lc - 1) : lc;
      for (int unsigned k = 1; k <= n; k++)
         send_byte(8'($urandom_range(0, 255)),
                   (form == FORM_CASE3 || form == FORM_SHORT_DATA) && k == n);
      if (form == FORM_CASE3 || form == FORM_SHORT_DATA) return;

      // Le, then trailing bytes when extra data is wanted.
      send_byte(8'($urandom_range(0, 255)), form == FORM_CASE4);
      if (form == FORM_EXTRA) begin
         n = $urandom_range(1, 3);
         for (int unsigned k = 1; k <= n; k++) send_byte(8'($urandom_range(0, 255)), k == n);
      end
   endtask

   function automatic string show(input parser_out_type r);
      return {$sformatf("kind %0d body %02h cla %02h ins %02h p1 %02h p2 %02h ",
                        r.kind, r.body, r.cla, r.ins, r.p1, r.p2),
              $sformatf("lc %02h le %03h case %0d st %0d eor %0d",
                        r.lc, r.le, r.acase, r.status, r.eor)};
   endfunction

   // Compare one popped transaction with the oldest prediction.
   task automatic check_result();
      parser_out_type got;
      parser_out_type want;
      got = '{rsp_result_kind, rsp_body_byte, rsp_class_byte, rsp_instruction_byte,
              rsp_param_one, rsp_param_two, rsp_command_length, rsp_expected_length,
              rsp_apdu_case, rsp_parse_status, rsp_end_of_run};
      if (parser_out_q.size() == 0) begin
         if (bad_count < MAX_SHOWN) $display("unexpected result: %s", show(got));
         bad_count++;
      end else begin
         want = parser_out_q.pop_front();
         if (got !== want) begin
            if (bad_count < MAX_SHOWN) begin
               $display("mismatch at %0t", $realtime);
               $display("  expected: %s", show(want));
               $display("  actual:   %s", show(got));
            end
            bad_count++;
         end
      end
   endtask

   // Result side: pop with random stall bursts, none once the run is calm.
   initial begin
      int unsigned stall_left;
      pop        = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_result();
         if (reset) begin
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Stimulus: reset, directed rows, then random APDUs, then drain.
   initial begin
      parser_out_type typed_out;
      reset         = 1'b1;
      push          = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      bad_count     = 0;
      sent_count    = 0;
      calm          = 1'b0;
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned i = 0; i < NUM_DIRECT; i++) begin
         send_byte(dir_rows[i].b, dir_rows[i].fin);
         // A typed row fixes the summary by hand in place of the prediction.
         if (dir_rows[i].typed) begin
            typed_out        = '0;
            typed_out.kind   = KIND_SUMMARY;
            typed_out.cla    = dir_rows[i].cla;
            typed_out.ins    = dir_rows[i].ins;
            typed_out.p1     = dir_rows[i].p1;
            typed_out.p2     = dir_rows[i].p2;
            typed_out.lc     = dir_rows[i].lc;
            typed_out.le     = dir_rows[i].le;
            typed_out.acase  = dir_rows[i].ac;
            typed_out.status = dir_rows[i].st;
            typed_out.eor    = 1'b1;
            parser_out_q[parser_out_q.size() - 1] = typed_out;
         end
      end

      while (sent_count < NUM_ITEMS) send_random_apdu();
      push <= 1'b0;

      while (parser_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (bad_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
